// ----- hw/rtl/gww_pkg.sv -----
// gww_pkg: shared types, constants and helpers of the greedy word wrap stream
// used by the front, the back and the top level of the block
`default_nettype none

package gww_pkg;

    localparam int PEND_DEPTH_DEF = 64;
    localparam int CMD_Q_DEPTH    = 2;

    localparam logic [5:0] MAX_LEN_CAP = 6'd60;
    localparam logic [5:0] COUNT_SAT   = 6'd63;
    localparam logic [7:0] DELIM_RST   = 8'h0A;

    // bits of one queued command that do not depend on the holding store size
    localparam int CMD_FIXED_W = 15;

    typedef enum logic [0:0] {
        CFG_MAX_LENGTH = 1'b0,
        CFG_LINE_DELIM = 1'b1
    } t_cfg_idx;

    typedef enum logic [1:0] {
        WS_SPACE = 2'd0,
        WS_TAB   = 2'd1,
        WS_CR    = 2'd2,
        WS_NL    = 2'd3
    } t_ws_code;

    function automatic logic is_ws(input logic [7:0] b);
        return (b == 8'h20) || (b == 8'h09) || (b == 8'h0D) || (b == 8'h0A);
    endfunction

    function automatic t_ws_code ws_code(input logic [7:0] b);
        t_ws_code c;
        case (b)
            8'h09: c = WS_TAB;
            8'h0D: c = WS_CR;
            8'h0A: c = WS_NL;
            default: c = WS_SPACE;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] ws_byte(input t_ws_code c);
        logic [7:0] b;
        case (c)
            WS_SPACE: b = 8'h20;
            WS_TAB:   b = 8'h09;
            WS_CR:    b = 8'h0D;
            WS_NL:    b = 8'h0A;
            default:  b = 8'h20;
        endcase
        return b;
    endfunction

    // continuation bytes (10xxxxxx) add nothing to the character count
    function automatic logic is_lead(input logic [7:0] b);
        return b[7:6] != 2'b10;
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/gww_in_if.sv -----
// gww_in_if: input channel of the word wrap stream, one text byte per word
// no dependencies
`default_nettype none

interface gww_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       is_last;

    modport source (output valid, output text_byte, output is_last, input ready);
    modport sink   (input valid, input text_byte, input is_last, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/gww_out_if.sv -----
// gww_out_if: output channel of the word wrap stream, one result per word
// no dependencies
`default_nettype none

interface gww_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       has_byte;
    logic       end_of_text;

    modport source (output valid, output out_byte, output has_byte, output end_of_text,
                    input ready);
    modport sink   (input valid, input out_byte, input has_byte, input end_of_text,
                    output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/gww_front.sv -----
// gww_front: accepts text bytes, tracks line state and turns each byte into a command
// depends on gww_pkg and gww_in_if
`default_nettype none

module gww_front #(
    parameter int PEND_DEPTH = gww_pkg::PEND_DEPTH_DEF,
    parameter int IDX_W      = $clog2(PEND_DEPTH),
    parameter int CNT_W      = $clog2(PEND_DEPTH + 1),
    parameter int CMD_W      = gww_pkg::CMD_FIXED_W + IDX_W + CNT_W
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    gww_in_if.sink                i_text,
    input  wire logic [5:0]       i_max_length,
    input  wire logic             i_q_full,
    output logic                  o_q_push,
    output logic [CMD_W-1:0]      o_q_data
);
    import gww_pkg::*;

    typedef struct packed {
        logic             hold;
        t_ws_code         hold_code;
        logic [IDX_W-1:0] hold_idx;
        logic             delim;
        logic [CNT_W-1:0] flush_n;
        logic             byte_v;
        logic [7:0]       data_byte;
        logic             last;
        logic             empty;
    } t_cmd;

    logic [5:0]       r_char_count, n_char_count;
    logic             r_content, n_content;
    logic             r_owed, n_owed;
    logic [CNT_W-1:0] r_pend_cnt, n_pend_cnt;

    t_cmd       cmd;
    logic       accept;
    logic       ws;
    t_ws_code   code;
    logic [5:0] base_count;
    logic [5:0] inc_count;

    assign i_text.ready = !i_q_full;
    assign accept       = i_text.valid && !i_q_full;
    assign o_q_push     = accept;
    assign o_q_data     = cmd;

    assign ws   = is_ws(i_text.text_byte);
    assign code = ws_code(i_text.text_byte);

    always_comb begin
        n_char_count = r_char_count;
        n_content    = r_content;
        n_owed       = r_owed;
        n_pend_cnt   = r_pend_cnt;
        base_count   = r_char_count;
        inc_count    = (r_char_count == COUNT_SAT) ? COUNT_SAT : r_char_count + 6'd1;
        cmd           = '0;
        cmd.hold_code = code;
        cmd.data_byte = i_text.text_byte;
        cmd.last      = i_text.is_last;

        if (!ws) begin
            if (!r_content) begin
                // first visible byte opens the line
                cmd.delim  = r_owed;
                n_owed     = 1'b0;
                n_content  = 1'b1;
                base_count = '0;
            end else begin
                cmd.flush_n = r_pend_cnt;
                n_pend_cnt  = '0;
            end
            cmd.byte_v = 1'b1;
            if (is_lead(i_text.text_byte) && base_count != COUNT_SAT) begin
                n_char_count = base_count + 6'd1;
            end else begin
                n_char_count = base_count;
            end
        end else if (!r_content) begin
            // leading whitespace is dropped, a newline ends an empty line
            n_char_count = '0;
            if (code == WS_NL) begin
                cmd.delim = r_owed;
                n_owed    = 1'b1;
            end
        end else begin
            if (code == WS_NL || inc_count > i_max_length) begin
                n_pend_cnt   = '0;
                n_char_count = '0;
                n_content    = 1'b0;
                n_owed       = 1'b1;
            end else begin
                n_char_count = inc_count;
                if (r_pend_cnt < CNT_W'(PEND_DEPTH)) begin
                    cmd.hold     = 1'b1;
                    cmd.hold_idx = r_pend_cnt[IDX_W-1:0];
                    n_pend_cnt   = r_pend_cnt + CNT_W'(1);
                end
            end
        end

        if (i_text.is_last) begin
            // final line keeps its held whitespace
            if (n_content && n_pend_cnt != '0) begin
                cmd.flush_n = n_pend_cnt;
            end
            cmd.empty    = !cmd.delim && cmd.flush_n == '0 && !cmd.byte_v;
            n_char_count = '0;
            n_content    = 1'b0;
            n_owed       = 1'b0;
            n_pend_cnt   = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_char_count <= '0;
            r_content    <= 1'b0;
            r_owed       <= 1'b0;
            r_pend_cnt   <= '0;
        end else if (accept) begin
            r_char_count <= n_char_count;
            r_content    <= n_content;
            r_owed       <= n_owed;
            r_pend_cnt   <= n_pend_cnt;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/gww_cmd_q.sv -----
// gww_cmd_q: short command queue between the front and the back of the word wrap stream
// depends on nothing but its parameters
`default_nettype none

module gww_cmd_q #(
    parameter int W     = 8,
    parameter int DEPTH = 2
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_push,
    input  wire logic [W-1:0] i_data,
    input  wire logic         i_pop,
    output logic [W-1:0]      o_data,
    output logic              o_full,
    output logic              o_empty
);
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [W-1:0]     r_slot [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = r_count == CNT_W'(DEPTH);
    assign o_empty = r_count == '0;
    assign o_data  = r_slot[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_data;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/gww_back.sv -----
// gww_back: carries out queued commands, owns the held whitespace store and the output register
// depends on gww_pkg and gww_out_if
`default_nettype none

module gww_back #(
    parameter int PEND_DEPTH = gww_pkg::PEND_DEPTH_DEF,
    parameter int IDX_W      = $clog2(PEND_DEPTH),
    parameter int CNT_W      = $clog2(PEND_DEPTH + 1),
    parameter int CMD_W      = gww_pkg::CMD_FIXED_W + IDX_W + CNT_W
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic [7:0]       i_line_delim,
    input  wire logic             i_q_empty,
    input  wire logic [CMD_W-1:0] i_q_data,
    output logic                  o_q_pop,
    gww_out_if.source             o_text
);
    import gww_pkg::*;

    typedef struct packed {
        logic             hold;
        t_ws_code         hold_code;
        logic [IDX_W-1:0] hold_idx;
        logic             delim;
        logic [CNT_W-1:0] flush_n;
        logic             byte_v;
        logic [7:0]       data_byte;
        logic             last;
        logic             empty;
    } t_cmd;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_DELIM = 6'b000010,
        S_RD    = 6'b000100,
        S_DATA  = 6'b001000,
        S_BYTE  = 6'b010000,
        S_EMPTY = 6'b100000
    } t_state;

    t_state           r_state, n_state;
    t_cmd             r_cmd, n_cmd;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic             r_out_valid, n_out_valid;
    logic [7:0]       r_out_byte, n_out_byte;
    logic             r_out_has, n_out_has;
    logic             r_out_end, n_out_end;

    t_ws_code         r_mem [PEND_DEPTH];
    t_ws_code         r_rd_code;

    t_cmd             q_cmd;
    logic             can_put;
    logic             last_entry;

    // next step of a command once the earlier steps are done
    function automatic t_state next_step(input t_cmd c, input logic skip_delim,
                                         input logic skip_flush);
        t_state s;
        if (c.delim && !skip_delim) begin
            s = S_DELIM;
        end else if (c.flush_n != '0 && !skip_flush) begin
            s = S_RD;
        end else if (c.byte_v) begin
            s = S_BYTE;
        end else if (c.empty) begin
            s = S_EMPTY;
        end else begin
            s = S_IDLE;
        end
        return s;
    endfunction

    assign q_cmd      = t_cmd'(i_q_data);
    assign can_put    = !r_out_valid || o_text.ready;
    assign last_entry = (CNT_W'(r_idx) + CNT_W'(1)) == r_cmd.flush_n;

    assign o_text.valid       = r_out_valid;
    assign o_text.out_byte    = r_out_byte;
    assign o_text.has_byte    = r_out_has;
    assign o_text.end_of_text = r_out_end;

    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_idx       = r_idx;
        n_out_valid = r_out_valid && !o_text.ready;
        n_out_byte  = r_out_byte;
        n_out_has   = r_out_has;
        n_out_end   = r_out_end;
        o_q_pop     = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (!i_q_empty) begin
                    o_q_pop = 1'b1;
                    n_cmd   = q_cmd;
                    n_idx   = '0;
                    n_state = next_step(q_cmd, 1'b0, 1'b0);
                end
            end
            S_DELIM: begin
                if (can_put) begin
                    n_out_valid = 1'b1;
                    n_out_byte  = i_line_delim;
                    n_out_has   = 1'b1;
                    n_out_end   = r_cmd.last && r_cmd.flush_n == '0 && !r_cmd.byte_v;
                    n_state     = next_step(r_cmd, 1'b1, 1'b0);
                end
            end
            S_RD: begin
                // the store read is registered; the code is ready in S_DATA
                n_state = S_DATA;
            end
            S_DATA: begin
                if (can_put) begin
                    n_out_valid = 1'b1;
                    n_out_byte  = ws_byte(r_rd_code);
                    n_out_has   = 1'b1;
                    n_out_end   = r_cmd.last && last_entry && !r_cmd.byte_v;
                    if (last_entry) begin
                        n_state = next_step(r_cmd, 1'b1, 1'b1);
                    end else begin
                        n_idx   = r_idx + IDX_W'(1);
                        n_state = S_RD;
                    end
                end
            end
            S_BYTE: begin
                if (can_put) begin
                    n_out_valid = 1'b1;
                    n_out_byte  = r_cmd.data_byte;
                    n_out_has   = 1'b1;
                    n_out_end   = r_cmd.last;
                    n_state     = S_IDLE;
                end
            end
            S_EMPTY: begin
                if (can_put) begin
                    n_out_valid = 1'b1;
                    n_out_byte  = '0;
                    n_out_has   = 1'b0;
                    n_out_end   = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd      <= n_cmd;
        r_idx      <= n_idx;
        r_out_byte <= n_out_byte;
        r_out_has  <= n_out_has;
        r_out_end  <= n_out_end;
    end

    // held whitespace store, written when a command is taken, read one entry per flush step
    always_ff @(posedge i_clk) begin
        if (o_q_pop && q_cmd.hold) begin
            r_mem[q_cmd.hold_idx] <= q_cmd.hold_code;
        end
        r_rd_code <= r_mem[r_idx];
    end

endmodule

`default_nettype wire

// ----- hw/rtl/greedy_word_wrap_stream.sv -----
// greedy_word_wrap_stream: top level, configuration registers and the front/queue/back split
// depends on gww_pkg, gww_in_if, gww_out_if, gww_front, gww_cmd_q and gww_back
`default_nettype none

// Greedy word wrap over a UTF-8 byte stream. The front takes one byte per cycle while
// its two-entry command queue has room; the back turns the commands into result words.
// For a visible byte the back fetches the command, then puts the byte out; a held
// whitespace byte needs only the command fetch. Each released held whitespace byte
// is read from the holding store through its registered read port before it goes out.
// A line delimiter or an end-of-text word takes its own state. A result waiting in the
// output register does not stop the front from taking further bytes. The holding store
// needs no clearing after reset: only entries written for the current line are read.
module greedy_word_wrap_stream #(
    parameter int PEND_DEPTH = gww_pkg::PEND_DEPTH_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    gww_in_if.sink                 i_text,
    gww_out_if.source              o_text,
    input  wire logic              i_cfg_we,
    input  wire gww_pkg::t_cfg_idx i_cfg_idx,
    input  wire logic [7:0]        i_cfg_data
);
    import gww_pkg::*;

    localparam int IDX_W = $clog2(PEND_DEPTH);
    localparam int CNT_W = $clog2(PEND_DEPTH + 1);
    localparam int CMD_W = CMD_FIXED_W + IDX_W + CNT_W;

    logic [5:0]       r_max_length;
    logic [7:0]       r_line_delim;

    logic             q_push;
    logic [CMD_W-1:0] q_in_data;
    logic             q_pop;
    logic [CMD_W-1:0] q_out_data;
    logic             q_full;
    logic             q_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_length <= MAX_LEN_CAP;
            r_line_delim <= DELIM_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MAX_LENGTH: begin
                    r_max_length <= (i_cfg_data[5:0] > MAX_LEN_CAP) ? MAX_LEN_CAP
                                                                     : i_cfg_data[5:0];
                end
                CFG_LINE_DELIM: begin
                    r_line_delim <= i_cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    gww_front #(
        .PEND_DEPTH (PEND_DEPTH),
        .IDX_W      (IDX_W),
        .CNT_W      (CNT_W),
        .CMD_W      (CMD_W)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_text       (i_text),
        .i_max_length (r_max_length),
        .i_q_full     (q_full),
        .o_q_push     (q_push),
        .o_q_data     (q_in_data)
    );

    gww_cmd_q #(
        .W     (CMD_W),
        .DEPTH (CMD_Q_DEPTH)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in_data),
        .i_pop   (q_pop),
        .o_data  (q_out_data),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    gww_back #(
        .PEND_DEPTH (PEND_DEPTH),
        .IDX_W      (IDX_W),
        .CNT_W      (CNT_W),
        .CMD_W      (CMD_W)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_line_delim (r_line_delim),
        .i_q_empty    (q_empty),
        .i_q_data     (q_out_data),
        .o_q_pop      (q_pop),
        .o_text       (o_text)
    );

endmodule

`default_nettype wire
